/* design/ptpcsc_pkg.sv */
// ----------------------------------------------------------------------------
// ptpcsc_pkg
// Types, register map and color conversion helpers for the packed ten-bit
// pixel unpacker with YCbCr to RGB conversion.
// ----------------------------------------------------------------------------
package ptpcsc_pkg;

   // Capture word: one byte per channel
   typedef struct packed {
      logic [7:0] red_byte;
      logic [7:0] green_byte;
      logic [7:0] blue_byte;
   } req_payload_type;

   // One output pixel
   typedef struct packed {
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
      logic       last_of_group;
   } rsp_payload_type;

   // Register map: 32-bit registers at byte address 4*index
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_COLOR_MODE = 1'b0;

   // Group geometry
   localparam int WORDS_PER_GROUP  = 5;
   localparam int PIXELS_PER_GROUP = 4;
   localparam int POS_W            = 3;
   localparam int CNT_W            = 3;

   // Q16 BT.601 full-range coefficients
   localparam int ACC_W = 28;
   localparam logic signed [ACC_W-1:0] K_RV = 28'sd91881;
   localparam logic signed [ACC_W-1:0] K_GU = 28'sd22554;
   localparam logic signed [ACC_W-1:0] K_GV = 28'sd46802;
   localparam logic signed [ACC_W-1:0] K_BU = 28'sd116130;
   localparam logic signed [ACC_W-1:0] CHROMA_BIAS = 28'sd128;

   // Drop 16 fraction bits, clamp to 0..255
   function automatic logic [7:0] sat_q16(input logic signed [ACC_W-1:0] acc);
      logic [7:0] res;
      if (acc < 0) begin
         res = 8'd0;
      end else if (acc[ACC_W-1:24] != '0) begin
         res = 8'hff;
      end else begin
         res = acc[23:16];
      end
      return res;
   endfunction

endpackage

/* design/packed_ten_bit_pixel_unpack_csc.sv */
// ----------------------------------------------------------------------------
// packed_ten_bit_pixel_unpack_csc
// Unpacks five capture words into four 8-bit pixels and optionally converts
// YCbCr to RGB (BT.601 full range).
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one capture word per transaction (red/Cr, green/Y, blue/Cb
//   bytes). Words one to four of a group are only stored. The fifth word
//   completes each channel's 40-bit stream; the top 8 bits of the four 10-bit
//   samples are latched into a four-pixel group buffer.
//   rsp_* delivers one pixel per transaction; last_of_group marks the fourth.
//   Once the fifth word is taken, the first pixel of a group moves from the
//   group buffer into the output register; the rest follow one per cycle while
//   rsp_ready stays high.
//   Throughput: one word per cycle while rsp_ready stays high, i.e. four
//   pixels per five words. The group buffer drains while rsp_ready stays high,
//   so it is empty again by the time the next fifth word can arrive; req_ready waits on it alone.
//   csr_* holds color_mode at address 0 (0 = pass RGB, 1 = convert YCbCr).
//   The mode in force when the fifth word is taken applies to that group.
//   Reset (synchronous, active high) clears the word position, the group
//   buffer, the output register and color_mode.
//   A stalled receiver holds the output register and the group buffer; while
//   the buffer holds pixels, the next fifth word waits, earlier words still enter.
// ----------------------------------------------------------------------------
module packed_ten_bit_pixel_unpack_csc
   import ptpcsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // capture word channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   // pixel channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ------------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------------
   logic                  color_mode_ff, color_mode_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [3:0][7:0]       red_words_ff, red_words_in;
   logic [3:0][7:0]       green_words_ff, green_words_in;
   logic [3:0][7:0]       blue_words_ff, blue_words_in;

   // group buffer: slot 0 is the next pixel to leave
   logic [PIXELS_PER_GROUP-1:0][7:0] red_smp_ff, red_smp_in;
   logic [PIXELS_PER_GROUP-1:0][7:0] green_smp_ff, green_smp_in;
   logic [PIXELS_PER_GROUP-1:0][7:0] blue_smp_ff, blue_smp_in;
   logic                  grp_mode_ff, grp_mode_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   // ------------------------------------------------------------------------
   // Control
   // ------------------------------------------------------------------------
   logic final_word;
   logic req_take;
   logic load_grp;
   logic move_pix;
   logic csr_wr;
   logic csr_hit_mode;

   assign final_word   = (pos_ff >= POS_W'(WORDS_PER_GROUP - 1));
   // hold the fifth word until the group buffer has drained
   assign req_ready    = !final_word || (cnt_ff == '0);
   assign req_take     = req_valid && req_ready;
   assign load_grp     = req_take && final_word;
   // advance a pixel whenever the output register is free or being emptied
   assign move_pix     = (cnt_ff != '0) && (!rsp_valid_ff || rsp_ready);

   assign csr_pready   = 1'b1;
   assign csr_wr       = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit_mode = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_COLOR_MODE);
   assign csr_prdata   = csr_hit_mode ? {{(CSR_DATA_W-1){1'b0}}, color_mode_ff} : '0;

   // ------------------------------------------------------------------------
   // Word collection and group load
   // ------------------------------------------------------------------------
   always_comb begin
      color_mode_in  = color_mode_ff;
      pos_in         = pos_ff;
      red_words_in   = red_words_ff;
      green_words_in = green_words_ff;
      blue_words_in  = blue_words_ff;
      red_smp_in     = red_smp_ff;
      green_smp_in   = green_smp_ff;
      blue_smp_in    = blue_smp_ff;
      grp_mode_in    = grp_mode_ff;
      cnt_in         = cnt_ff;

      if (csr_wr && csr_hit_mode) begin
         color_mode_in = csr_pwdata[0];
      end

      // store words one to four into their byte lanes
      if (req_take && !final_word) begin
         for (int k = 0; k < 4; k++) begin
            if (pos_ff == POS_W'(k)) begin
               red_words_in[k]   = req_data.red_byte;
               green_words_in[k] = req_data.green_byte;
               blue_words_in[k]  = req_data.blue_byte;
            end
         end
         pos_in = pos_ff + POS_W'(1);
      end

      // shift the group buffer down by one pixel
      if (move_pix) begin
         for (int s = 0; s < PIXELS_PER_GROUP - 1; s++) begin
            red_smp_in[s]   = red_smp_ff[s+1];
            green_smp_in[s] = green_smp_ff[s+1];
            blue_smp_in[s]  = blue_smp_ff[s+1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end

      // fifth word: pick stream bits 39:32, 29:22, 19:12 and 9:2
      if (load_grp) begin
         red_smp_in   = {red_words_ff[1][1:0],   red_words_ff[0][7:2],
                         red_words_ff[2][3:0],   red_words_ff[1][7:4],
                         red_words_ff[3][5:0],   red_words_ff[2][7:6],
                         req_data.red_byte};
         green_smp_in = {green_words_ff[1][1:0], green_words_ff[0][7:2],
                         green_words_ff[2][3:0], green_words_ff[1][7:4],
                         green_words_ff[3][5:0], green_words_ff[2][7:6],
                         req_data.green_byte};
         blue_smp_in  = {blue_words_ff[1][1:0],  blue_words_ff[0][7:2],
                         blue_words_ff[2][3:0],  blue_words_ff[1][7:4],
                         blue_words_ff[3][5:0],  blue_words_ff[2][7:6],
                         req_data.blue_byte};
         grp_mode_in  = color_mode_ff;
         cnt_in       = CNT_W'(PIXELS_PER_GROUP);
         pos_in       = '0;
      end
   end

   // ------------------------------------------------------------------------
   // Color conversion of buffer slot 0 into the output register
   // ------------------------------------------------------------------------
   logic signed [ACC_W-1:0] y_q;
   logic signed [ACC_W-1:0] cb_s;
   logic signed [ACC_W-1:0] cr_s;
   logic signed [ACC_W-1:0] acc_r;
   logic signed [ACC_W-1:0] acc_g;
   logic signed [ACC_W-1:0] acc_b;

   always_comb begin
      y_q   = signed'({{(ACC_W-24){1'b0}}, green_smp_ff[0], 16'h0000});
      cb_s  = signed'({{(ACC_W-8){1'b0}}, blue_smp_ff[0]}) - CHROMA_BIAS;
      cr_s  = signed'({{(ACC_W-8){1'b0}}, red_smp_ff[0]}) - CHROMA_BIAS;
      acc_r = y_q + K_RV * cr_s;
      acc_g = y_q - K_GU * cb_s - K_GV * cr_s;
      acc_b = y_q + K_BU * cb_s;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (move_pix) begin
         rsp_valid_in = 1'b1;
         if (grp_mode_ff) begin
            rsp_data_in.red_out   = sat_q16(acc_r);
            rsp_data_in.green_out = sat_q16(acc_g);
            rsp_data_in.blue_out  = sat_q16(acc_b);
         end else begin
            rsp_data_in.red_out   = red_smp_ff[0];
            rsp_data_in.green_out = green_smp_ff[0];
            rsp_data_in.blue_out  = blue_smp_ff[0];
         end
         rsp_data_in.last_of_group = (cnt_ff == CNT_W'(1));
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= 1'b0;
         pos_ff        <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         color_mode_ff <= color_mode_in;
         pos_ff        <= pos_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      red_words_ff   <= red_words_in;
      green_words_ff <= green_words_in;
      blue_words_ff  <= blue_words_in;
      red_smp_ff     <= red_smp_in;
      green_smp_ff   <= green_smp_in;
      blue_smp_ff    <= blue_smp_in;
      grp_mode_ff    <= grp_mode_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // a fifth word only enters an empty group buffer
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      load_grp |-> (cnt_ff == '0))
      else $error("group loaded over pending pixels");

   // a loaded group holds exactly four pixels, word position restarts
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load_grp |=> (cnt_ff == CNT_W'(PIXELS_PER_GROUP)) && (pos_ff == '0))
      else $error("group load did not set count and position");

   // the last pixel of a group comes out valid and flagged last_of_group
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (move_pix && (cnt_ff == CNT_W'(1))) |=> rsp_valid && rsp_data.last_of_group)
      else $error("last pixel not flagged");

   // counters stay in range
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CNT_W'(PIXELS_PER_GROUP)) && (pos_ff <= POS_W'(WORDS_PER_GROUP - 1)))
      else $error("group counters out of range");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the packed ten-bit pixel unpacker. Capture words go
// in on req_*, pixels come back on rsp_* and are checked field by field
// against an in-bench model of the five-word unpack and the BT.601
// full-range conversion. The color mode is switched over the APB-style csr_*
// port between phases, only once all queued words are taken and all pixels checked.
// ----------------------------------------------------------------------------
module testbench;
   import ptpcsc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {
      MODE_PASS  = 1'b0,
      MODE_YCBCR = 1'b1
   } color_mode_e;

   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR  = CSR_ADDR_W'(CSR_IDX_COLOR_MODE) << 2;
   // One register slot past color_mode; writes there must be ignored.
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = MODE_ADDR + CSR_ADDR_W'(4);
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Model state: partial group per channel, next word slot, active mode
   logic [31:0]     red_acc = '0;
   logic [31:0]     green_acc = '0;
   logic [31:0]     blue_acc = '0;
   logic [2:0]      word_idx = '0;
   color_mode_e     mode_shadow = MODE_PASS;

   req_payload_type word_queue[$];    // capture words not yet offered
   rsp_payload_type pixel_queue[$];   // pixels predicted, not yet seen

   int error_count = 0;
   int words_sent = 0;
   int pixels_checked = 0;
   int pixels_converted = 0;
   int csr_writes = 0;
   int send_gap = 0;
   int send_burst = 0;
   int recv_stall = 0;
   int recv_burst = 0;
   int idle_cycles = 0;

   packed_ten_bit_pixel_unpack_csc dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #4 clock = ~clock;

   // Drop the 16 fraction bits and clamp to a byte; negative sums give zero.
   function automatic logic [7:0] clamp_q16(input int acc);
      int whole;
      whole = acc >>> 16;
      if (acc < 0) return 8'd0;
      if (whole > 255) return 8'hff;
      return whole[7:0];
   endfunction

   // Store one capture word; on the fifth word of a group, predict the four
   // pixels with the mode in force right now.
   task automatic unpack_word(input req_payload_type w);
      logic [39:0]     rs, gs, bs;
      rsp_payload_type px;
      int              y, cb, cr, p;
      if (word_idx < 3'd4) begin
         red_acc[8*word_idx +: 8]   = w.red_byte;
         green_acc[8*word_idx +: 8] = w.green_byte;
         blue_acc[8*word_idx +: 8]  = w.blue_byte;
         word_idx = word_idx + 3'd1;
      end else begin
         rs = {w.red_byte, red_acc};
         gs = {w.green_byte, green_acc};
         bs = {w.blue_byte, blue_acc};
         for (p = 0; p < 4; p++) begin
            // Upper 8 bits of each 10-bit sample, first sample at the top
            if (mode_shadow == MODE_PASS) begin
               px.red_out   = rs[39-10*p -: 8];
               px.green_out = gs[39-10*p -: 8];
               px.blue_out  = bs[39-10*p -: 8];
            end else begin
               y  = gs[39-10*p -: 8];
               cb = bs[39-10*p -: 8];
               cr = rs[39-10*p -: 8];
               cb -= 128;
               cr -= 128;
               px.red_out   = clamp_q16(y * 65536 + 91881 * cr);
               px.green_out = clamp_q16(y * 65536 - 22554 * cb - 46802 * cr);
               px.blue_out  = clamp_q16(y * 65536 + 116130 * cb);
               pixels_converted++;
            end
            px.last_of_group = (p == 3);
            pixel_queue.push_back(px);
         end
         red_acc   = '0;
         green_acc = '0;
         blue_acc  = '0;
         word_idx  = '0;
      end
   endtask

   // Idle length after a transaction: mostly none or short, a few long,
   // and now and then a burst of back-to-back transactions.
   function automatic int pick_gap(inout int burst_left);
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_byte();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return 8'h00;
      if (roll < 20) return 8'hff;
      if (roll < 30) return 8'($urandom_range(126, 130));
      return 8'($urandom);
   endfunction

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
         error_count++;
      end
   endtask

   task automatic push_word(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      req_payload_type w;
      w.red_byte   = r;
      w.green_byte = g;
      w.blue_byte  = b;
      word_queue.push_back(w);
   endtask

   // Build one five-word group from four pixels per channel; the two low
   // bits of every 10-bit sample are random filler.
   task automatic push_group(input logic [7:0] r[4], input logic [7:0] g[4],
                             input logic [7:0] b[4]);
      logic [39:0] rs, gs, bs;
      int          p, k;
      rs = 40'({$urandom, $urandom});
      gs = 40'({$urandom, $urandom});
      bs = 40'({$urandom, $urandom});
      for (p = 0; p < 4; p++) begin
         rs[39-10*p -: 8] = r[p];
         gs[39-10*p -: 8] = g[p];
         bs[39-10*p -: 8] = b[p];
      end
      for (k = 0; k < 5; k++) push_word(rs[8*k +: 8], gs[8*k +: 8], bs[8*k +: 8]);
   endtask

   // Hold until every word is taken and every pixel has come back, then let
   // the pipeline settle before touching the registers.
   task automatic wait_drained();
      @(negedge clock);
      while (word_queue.size() != 0 || req_valid || pixel_queue.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands at the access edge.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == MODE_ADDR) mode_shadow = color_mode_e'(data[0]);
      csr_writes++;
   endtask

   // Upper data bits are don't-care for the mode register; randomize them.
   task automatic set_mode(input color_mode_e m);
      write_csr(MODE_ADDR, {31'($urandom), m});
   endtask

   // Sender: offer the next queued word once the current one is taken,
   // after the chosen idle gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            unpack_word(req_data);
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0 || word_queue.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
               req_valid <= 1'b1;
               req_data  <= word_queue.pop_front();
               send_gap  <= pick_gap(send_burst);
            end
         end
      end
   end

   // Receiver: check every pixel transaction against the oldest prediction,
   // and stall at random.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_queue.size() == 0) begin
               $display("%0t: unexpected pixel, expected none, actual %h", $realtime, rsp_data);
               error_count++;
            end else begin
               want = pixel_queue.pop_front();
               report_field("blue_out", want.blue_out, rsp_data.blue_out);
               report_field("green_out", want.green_out, rsp_data.green_out);
               report_field("red_out", want.red_out, rsp_data.red_out);
               report_field("last_of_group", want.last_of_group, rsp_data.last_of_group);
               pixels_checked++;
            end
         end
         if (recv_stall > 0) begin
            rsp_ready  <= 1'b0;
            recv_stall <= recv_stall - 1;
         end else begin
            rsp_ready  <= 1'b1;
            recv_stall <= pick_gap(recv_burst);
         end
      end
   end

   // Watchdog: any transaction or register access counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, %0d words queued, %0d pixels outstanding",
                  $realtime, word_queue.size(), pixel_queue.size());
         $display("testbench: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [7:0]  r[4], g[4], b[4];
      int          phase, n, groups, extra;
      color_mode_e next_mode;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, pass-through mode (reset value): all ones, all zeros,
      // then distinct bit patterns per channel and pixel.
      for (n = 0; n < 5; n++) push_word(8'hff, 8'hff, 8'hff);
      for (n = 0; n < 5; n++) push_word(8'h00, 8'h00, 8'h00);
      r = '{8'h01, 8'h80, 8'haa, 8'h55};
      g = '{8'h55, 8'haa, 8'h7f, 8'hfe};
      b = '{8'hf0, 8'h0f, 8'hc3, 8'h3c};
      push_group(r, g, b);

      // Mode change in the middle of a group: the mode at the fifth word wins.
      push_word(pick_byte(), pick_byte(), pick_byte());
      push_word(pick_byte(), pick_byte(), pick_byte());
      wait_drained();
      set_mode(MODE_YCBCR);
      @(negedge clock);
      for (n = 0; n < 3; n++) push_word(pick_byte(), pick_byte(), pick_byte());

      // Conversion extremes: saturate high, all-zero, neutral gray, and a
      // low-chroma pixel that overflows green.
      r = '{8'd255, 8'd0, 8'd128, 8'd0};
      g = '{8'd255, 8'd0, 8'd128, 8'd255};
      b = '{8'd255, 8'd0, 8'd128, 8'd0};
      push_group(r, g, b);
      wait_drained();

      // Write past the only register; the mode must stay at YCbCr.
      write_csr(SPARE_ADDR, 32'h0);

      // Random phases, alternating modes, with partial groups that can stay open
      // across the register writes.
      next_mode = MODE_YCBCR;
      for (phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            wait_drained();
            next_mode = (next_mode == MODE_PASS) ? MODE_YCBCR : MODE_PASS;
            set_mode(next_mode);
         end
         @(negedge clock);
         groups = $urandom_range(14, 20);
         extra  = $urandom_range(0, 4);
         for (n = 0; n < groups; n++) begin
            foreach (r[i]) begin
               r[i] = pick_byte();
               g[i] = pick_byte();
               b[i] = pick_byte();
            end
            push_group(r, g, b);
         end
         for (n = 0; n < extra; n++) push_word(pick_byte(), pick_byte(), pick_byte());
      end

      // Drain, then give stray pixels a chance to show up.
      wait_drained();
      repeat (10) @(negedge clock);

      $display("covered %0d capture words, %0d pixels checked (%0d predicted via YCbCr)",
               words_sent, pixels_checked, pixels_converted);
      $display("%0d register writes, including a mid-group mode change and an unmapped slot",
               csr_writes);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

/* files.f */
design/ptpcsc_pkg.sv
design/packed_ten_bit_pixel_unpack_csc.sv
tb/testbench.sv
